### sv/hrc_pkg.sv
// Shared types, constants and the hex character decoder for the hex color converter.
// Used by the channel decoder, the top level and the testbench.
`default_nettype none

package hrc_pkg;

    localparam int OUT_BITS    = 8;
    localparam int CHAR_BITS   = 8;
    localparam int NIBBLE_BITS = 4;

    localparam logic [NIBBLE_BITS-1:0] NIBBLE_MASK = 4'b1111;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_F = 8'h66;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [CHAR_BITS-1:0] LETTER_BASE  = 8'd10;

    typedef struct packed {
        logic [CHAR_BITS-1:0] red_high_digit;
        logic [CHAR_BITS-1:0] red_low_digit;
        logic [CHAR_BITS-1:0] green_high_digit;
        logic [CHAR_BITS-1:0] green_low_digit;
        logic [CHAR_BITS-1:0] blue_high_digit;
        logic [CHAR_BITS-1:0] blue_low_digit;
    } in_word_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] red_level;
        logic [OUT_BITS-1:0] green_level;
        logic [OUT_BITS-1:0] blue_level;
        logic [OUT_BITS-1:0] cyan_ink;
        logic [OUT_BITS-1:0] magenta_ink;
        logic [OUT_BITS-1:0] yellow_ink;
        logic [OUT_BITS-1:0] black_ink;
        logic                bad_digit;
    } out_word_t;

    typedef struct packed {
        logic                   bad;
        logic [NIBBLE_BITS-1:0] value;
    } nib_dec_t;

    // A character that is not a hex digit decodes as zero and is flagged.
    function automatic nib_dec_t decode_nibble(input logic [CHAR_BITS-1:0] c);
        nib_dec_t d;
        d.bad   = 1'b0;
        d.value = '0;
        priority if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d.value = NIBBLE_BITS'(c - CHAR_ZERO) & NIBBLE_MASK;
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
        begin
            d.value = NIBBLE_BITS'(c - CHAR_LOWER_A + LETTER_BASE) & NIBBLE_MASK;
        end
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
        begin
            d.value = NIBBLE_BITS'(c - CHAR_UPPER_A + LETTER_BASE) & NIBBLE_MASK;
        end
        else
        begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### sv/hrc_stream_if.sv
// Valid/ready stream interface carrying one word per handshake.
// The word type is set at instantiation, normally a struct from hrc_pkg.
`default_nettype none

interface hrc_stream_if #(parameter type word_t = logic);

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

### sv/hrc_chan_decode.sv
// One decode lane: turns a pair of ASCII hex characters into a channel level.
// Depends on hrc_pkg for the nibble decoder.
`default_nettype none

module hrc_chan_decode #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic [hrc_pkg::CHAR_BITS-1:0] high_char,
    input  wire logic [hrc_pkg::CHAR_BITS-1:0] low_char,
    output logic      [CHANNEL_BITS-1:0]       level,
    output logic                               bad
);

    hrc_pkg::nib_dec_t high_dec;
    hrc_pkg::nib_dec_t low_dec;

    assign high_dec = hrc_pkg::decode_nibble(high_char);
    assign low_dec  = hrc_pkg::decode_nibble(low_char);

    // The byte is cut down to the channel width, or zero extended above it.
    assign level = CHANNEL_BITS'({high_dec.value, low_dec.value});
    assign bad   = high_dec.bad | low_dec.bad;

endmodule

`default_nettype wire

### sv/hrc_key_merge.sv
// Merging stage: finds black as the least inverted channel and forms each
// ink's scaled numerator and the shared divisor. No package dependencies.
`default_nettype none

module hrc_key_merge #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic [2:0][CHANNEL_BITS-1:0]   level,
    output logic      [CHANNEL_BITS-1:0]        key,
    output logic      [2:0][2*CHANNEL_BITS-1:0] num,
    output logic      [CHANNEL_BITS-1:0]        den
);

    localparam int CB = CHANNEL_BITS;
    localparam int RW = 2 * CHANNEL_BITS;
    localparam logic [CB-1:0] FULL = '1;

    logic [2:0][CB-1:0] inv;
    logic [2:0][CB-1:0] diff;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            inv[i] = FULL - level[i];
        end
        key = inv[0];
        if (inv[1] < key)
        begin
            key = inv[1];
        end
        if (inv[2] < key)
        begin
            key = inv[2];
        end
        // Times full scale is a shift and a subtract.
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = inv[i] - key;
            num[i]  = {diff[i], CB'(0)} - RW'(diff[i]);
        end
        // For pure black every numerator is zero; any nonzero divisor gives zero.
        den = (key == FULL) ? FULL : FULL - key;
    end

endmodule

`default_nettype wire

### sv/hrc_ink_div.sv
// One ink lane: pipelined restoring divider, one quotient bit per stage.
// The quotient never exceeds full scale, so CHANNEL_BITS stages suffice.
`default_nettype none

module hrc_ink_div #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                        clk,
    input  wire logic [CHANNEL_BITS-1:0]     en,
    input  wire logic [2*CHANNEL_BITS-1:0]   num,
    input  wire logic [CHANNEL_BITS-1:0]     den,
    output logic      [CHANNEL_BITS-1:0]     quotient
);

    localparam int CB = CHANNEL_BITS;
    localparam int RW = 2 * CHANNEL_BITS;

    logic [RW-1:0] rem_reg [CB-1];
    logic [CB-1:0] den_reg [CB-1];
    logic [CB-1:0] quo_reg [CB];

    genvar s;
    generate
        for (s = 0; s < CB; s++)
        begin : g_stage
            logic [RW-1:0] rem_in;
            logic [CB-1:0] den_in;
            logic [CB-1:0] quo_in;
            logic [RW:0]   trial;
            logic [RW-1:0] rem_next;
            logic [CB-1:0] quo_next;

            if (s == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign den_in = den_reg[s-1];
                assign quo_in = quo_reg[s-1];
            end

            assign trial    = {1'b0, rem_in} - ({1'b0, RW'(den_in)} << (CB - 1 - s));
            assign rem_next = trial[RW] ? rem_in : trial[RW-1:0];
            assign quo_next = trial[RW] ? quo_in : (quo_in | (CB'(1) << (CB - 1 - s)));

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    quo_reg[s] <= quo_next;
                end
            end

            if (s < CB - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en[s])
                    begin
                        rem_reg[s] <= rem_next;
                        den_reg[s] <= den_in;
                    end
                end
            end
        end
    endgenerate

    assign quotient = quo_reg[CB-1];

endmodule

`default_nettype wire

### sv/hex_rgb_to_cmyk.sv
// Hex color to CMYK converter. Takes one word of six ASCII hex characters
// (RRGGBB) per clock and returns the decoded levels, the C, M, Y and K inks
// at full scale 2^CHANNEL_BITS-1, and a flag for any non-hex character. The
// pipeline registers the decode, then the black merge, then one quotient bit
// per stage in the three ink dividers, which run side by side. A new word is
// taken every clock unless every stage is full and the result waits; stalled
// stages collapse bubbles, so intake goes on while any stage is empty.
// Depends on hrc_pkg, hrc_stream_if, hrc_chan_decode, hrc_key_merge, hrc_ink_div.
`default_nettype none

module hex_rgb_to_cmyk #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    hrc_stream_if.sink         hex,
    hrc_stream_if.source       color
);

    localparam int CB     = CHANNEL_BITS;
    localparam int RW     = 2 * CHANNEL_BITS;
    localparam int STAGES = CHANNEL_BITS + 2;
    localparam int OB     = hrc_pkg::OUT_BITS;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] en;

    // Decode lanes
    logic [2:0][CB-1:0] level;
    logic [2:0]         lane_bad;

    hrc_chan_decode #(.CHANNEL_BITS(CB)) u_dec_red (
        .high_char (hex.data.red_high_digit),
        .low_char  (hex.data.red_low_digit),
        .level     (level[0]),
        .bad       (lane_bad[0])
    );

    hrc_chan_decode #(.CHANNEL_BITS(CB)) u_dec_green (
        .high_char (hex.data.green_high_digit),
        .low_char  (hex.data.green_low_digit),
        .level     (level[1]),
        .bad       (lane_bad[1])
    );

    hrc_chan_decode #(.CHANNEL_BITS(CB)) u_dec_blue (
        .high_char (hex.data.blue_high_digit),
        .low_char  (hex.data.blue_low_digit),
        .level     (level[2]),
        .bad       (lane_bad[2])
    );

    logic [2:0][CB-1:0] level_a_reg;
    logic               bad_a_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            level_a_reg <= level;
            bad_a_reg   <= |lane_bad;
        end
    end

    // Merge stage
    logic [CB-1:0]        key;
    logic [2:0][RW-1:0]   num;
    logic [CB-1:0]        den;

    hrc_key_merge #(.CHANNEL_BITS(CB)) u_merge (
        .level (level_a_reg),
        .key   (key),
        .num   (num),
        .den   (den)
    );

    hrc_pkg::out_word_t   side_b_reg;
    logic [2:0][RW-1:0]   num_b_reg;
    logic [CB-1:0]        den_b_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side_b_reg.red_level   <= OB'(level_a_reg[0]);
            side_b_reg.green_level <= OB'(level_a_reg[1]);
            side_b_reg.blue_level  <= OB'(level_a_reg[2]);
            side_b_reg.cyan_ink    <= '0;
            side_b_reg.magenta_ink <= '0;
            side_b_reg.yellow_ink  <= '0;
            side_b_reg.black_ink   <= OB'(key);
            side_b_reg.bad_digit   <= bad_a_reg;
            num_b_reg              <= num;
            den_b_reg              <= den;
        end
    end

    // Ink divider lanes
    logic [2:0][CB-1:0] ink;

    genvar lane;
    generate
        for (lane = 0; lane < 3; lane++)
        begin : g_ink
            hrc_ink_div #(.CHANNEL_BITS(CB)) u_div (
                .clk      (clk),
                .en       (en[STAGES-1:2]),
                .num      (num_b_reg[lane]),
                .den      (den_b_reg),
                .quotient (ink[lane])
            );
        end
    endgenerate

    // The decoded levels, black and the flag ride alongside the dividers.
    hrc_pkg::out_word_t side_d_reg [CB];

    genvar s;
    generate
        for (s = 0; s < CB; s++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (en[s+2])
                begin
                    if (s == 0)
                    begin
                        side_d_reg[s] <= side_b_reg;
                    end
                    else
                    begin
                        side_d_reg[s] <= side_d_reg[(s == 0) ? 0 : s-1];
                    end
                end
            end
        end
    endgenerate

    // A stage loads when it is empty or the stage after it moves on.
    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || color.ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= (i == 0) ? hex.valid : valid_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    assign hex.ready   = en[0];
    assign color.valid = valid_reg[STAGES-1];

    always_comb
    begin
        color.data             = side_d_reg[CB-1];
        color.data.cyan_ink    = OB'(ink[0]);
        color.data.magenta_ink = OB'(ink[1]);
        color.data.yellow_ink  = OB'(ink[2]);
    end

endmodule

`default_nettype wire

### tb/tb_hex_rgb_to_cmyk.sv
`timescale 1ns / 100ps
// Self-checking testbench for hex_rgb_to_cmyk: directed and random hex color words
// with random idling on both streams, checked against a behavioral CMYK predictor.
// Depends on hrc_pkg, hrc_stream_if and the hex_rgb_to_cmyk RTL.

module tb_hex_rgb_to_cmyk;

    localparam int CHANNEL_BITS  = 8;
    localparam int FULL_SCALE    = (1 << CHANNEL_BITS) - 1;
    localparam int MAX_IDLE      = 14;
    localparam int RANDOM_WORDS  = 700;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int BURST_FIRST   = 280;
    localparam int BURST_LAST    = 400;
    localparam int DRAIN_AT      = 450;
    localparam int SETTLE_CYCLES = 2 * (CHANNEL_BITS + 2);
    localparam int STALL_LIMIT   = 4000;

    typedef struct {
        hrc_pkg::in_word_t word;
        int                gap_after;
        bit                drain_first;
    } pending_color_t;

    logic clk;
    logic rst_n;

    hrc_stream_if #(.word_t(hrc_pkg::in_word_t))  hex_bus ();
    hrc_stream_if #(.word_t(hrc_pkg::out_word_t)) color_bus ();

    hex_rgb_to_cmyk #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hex   (hex_bus),
        .color (color_bus)
    );

    pending_color_t     pending_colors[$];
    hrc_pkg::out_word_t expected_colors[$];

    int colors_in    = 0;
    int colors_out   = 0;
    int errors       = 0;
    int gap_left     = 0;
    int rx_wait      = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int stall_cycles = 0;

    string HEX_CHARS = "0123456789abcdefABCDEF";

    always #4 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic int nibble_of(input logic [hrc_pkg::CHAR_BITS-1:0] c, inout bit bad);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        bad = 1'b1;
        return 0;
    endfunction

    function automatic int level_of(input logic [hrc_pkg::CHAR_BITS-1:0] hi,
                                    input logic [hrc_pkg::CHAR_BITS-1:0] lo, inout bit bad);
        int h;
        int l;
        h = nibble_of(hi, bad);
        l = nibble_of(lo, bad);
        return ((h << 4) | l) & FULL_SCALE;
    endfunction

    function automatic int ink_of(input int inverted, input int key);
        if (key >= FULL_SCALE)
            return 0;
        return ((inverted - key) * FULL_SCALE) / (FULL_SCALE - key);
    endfunction

    function automatic hrc_pkg::out_word_t cmyk_of(input hrc_pkg::in_word_t w);
        hrc_pkg::out_word_t o;
        bit                 bad;
        int                 r;
        int                 g;
        int                 b;
        int                 key;
        bad = 1'b0;
        r   = level_of(w.red_high_digit, w.red_low_digit, bad);
        g   = level_of(w.green_high_digit, w.green_low_digit, bad);
        b   = level_of(w.blue_high_digit, w.blue_low_digit, bad);
        key = FULL_SCALE - r;
        if (FULL_SCALE - g < key)
            key = FULL_SCALE - g;
        if (FULL_SCALE - b < key)
            key = FULL_SCALE - b;
        o.red_level   = hrc_pkg::OUT_BITS'(r);
        o.green_level = hrc_pkg::OUT_BITS'(g);
        o.blue_level  = hrc_pkg::OUT_BITS'(b);
        o.cyan_ink    = hrc_pkg::OUT_BITS'(ink_of(FULL_SCALE - r, key));
        o.magenta_ink = hrc_pkg::OUT_BITS'(ink_of(FULL_SCALE - g, key));
        o.yellow_ink  = hrc_pkg::OUT_BITS'(ink_of(FULL_SCALE - b, key));
        o.black_ink   = hrc_pkg::OUT_BITS'(key);
        o.bad_digit   = bad;
        return o;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic hrc_pkg::in_word_t word_of(input string s);
        hrc_pkg::in_word_t w;
        w.red_high_digit   = s[0];
        w.red_low_digit    = s[1];
        w.green_high_digit = s[2];
        w.green_low_digit  = s[3];
        w.blue_high_digit  = s[4];
        w.blue_low_digit   = s[5];
        return w;
    endfunction

    function automatic logic [hrc_pkg::CHAR_BITS-1:0] rand_hex_digit();
        return HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)];
    endfunction

    // Any byte at all, so that every bit of a character field is exercised.
    function automatic logic [hrc_pkg::CHAR_BITS-1:0] noisy_char();
        if ($urandom_range(0, 99) < 30)
            return hrc_pkg::CHAR_BITS'($urandom_range(0, 255));
        return rand_hex_digit();
    endfunction

    function automatic hrc_pkg::in_word_t random_color();
        hrc_pkg::in_word_t w;
        int                kind;
        string             pair;
        kind = $urandom_range(0, 99);
        w = word_of(string'({rand_hex_digit(), rand_hex_digit(), rand_hex_digit(),
                             rand_hex_digit(), rand_hex_digit(), rand_hex_digit()}));
        if (kind >= 70 && kind < 80)
        begin
            // Gray: equal channels, so all inks but black come out zero.
            case ($urandom_range(0, 3))
                0: pair = "00";
                1: pair = "ff";
                default: pair = string'({rand_hex_digit(), rand_hex_digit()});
            endcase
            w = word_of({pair, pair, pair});
        end
        else if (kind >= 80 && kind < 88)
        begin
            if ($urandom_range(0, 1))
            begin
                w.red_high_digit = "0";
                w.red_low_digit  = "0";
            end
            if ($urandom_range(0, 1))
            begin
                w.green_high_digit = "F";
                w.green_low_digit  = "f";
            end
            if ($urandom_range(0, 1))
            begin
                w.blue_high_digit = "0";
                w.blue_low_digit  = "0";
            end
        end
        else if (kind >= 88)
        begin
            w.red_high_digit   = noisy_char();
            w.red_low_digit    = noisy_char();
            w.green_high_digit = noisy_char();
            w.green_low_digit  = noisy_char();
            w.blue_high_digit  = noisy_char();
            w.blue_low_digit   = noisy_char();
        end
        return w;
    endfunction

    task automatic queue_color(input hrc_pkg::in_word_t w, input int gap, input bit drain);
        pending_color_t p;
        p.word        = w;
        p.gap_after   = gap;
        p.drain_first = drain;
        pending_colors.push_back(p);
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------- sender

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_bus.valid <= 1'b0;
            hex_bus.data  <= '0;
            gap_left      <= 0;
        end
        else if (!hex_bus.valid || hex_bus.ready)
        begin
            if (gap_left != 0)
            begin
                hex_bus.valid <= 1'b0;
                gap_left      <= gap_left - 1;
            end
            else if (pending_colors.size() != 0 &&
                     (!pending_colors[0].drain_first ||
                      (!hex_bus.valid && colors_in == colors_out)))
            begin
                hex_bus.valid <= 1'b1;
                hex_bus.data  <= pending_colors[0].word;
                gap_left      <= pending_colors[0].gap_after;
                void'(pending_colors.pop_front());
            end
            else
            begin
                hex_bus.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_bus.ready <= 1'b0;
            rx_wait   = 0;
            hold_left = 0;
        end
        else
        begin
            if (color_bus.valid && color_bus.ready)
                rx_wait = (((colors_out / 64) % 3) == 1) ? 0 : $urandom_range(0, MAX_IDLE);
            else if (rx_wait != 0)
                rx_wait--;
            // One long hold-off while the sender keeps streaming, to fill the pipeline.
            if (!hold_done && colors_in >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            else if (hold_left != 0)
            begin
                hold_left--;
            end
            color_bus.ready <= (rx_wait == 0 && hold_left == 0);
        end
    end

    // ---------------------------------------------------------------- monitor and checker

    always @(posedge clk)
    begin
        hrc_pkg::out_word_t got;
        hrc_pkg::out_word_t want;
        if (rst_n)
        begin
            if (hex_bus.valid && hex_bus.ready)
            begin
                expected_colors.push_back(cmyk_of(hex_bus.data));
                colors_in <= colors_in + 1;
            end
            if (color_bus.valid && color_bus.ready)
            begin
                colors_out <= colors_out + 1;
                got = color_bus.data;
                if (expected_colors.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word %h", got));
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (got.red_level !== want.red_level)
                        report_mismatch($sformatf("red_level %0d, want %0d",
                                                  got.red_level, want.red_level));
                    if (got.green_level !== want.green_level)
                        report_mismatch($sformatf("green_level %0d, want %0d",
                                                  got.green_level, want.green_level));
                    if (got.blue_level !== want.blue_level)
                        report_mismatch($sformatf("blue_level %0d, want %0d",
                                                  got.blue_level, want.blue_level));
                    if (got.cyan_ink !== want.cyan_ink)
                        report_mismatch($sformatf("cyan_ink %0d, want %0d",
                                                  got.cyan_ink, want.cyan_ink));
                    if (got.magenta_ink !== want.magenta_ink)
                        report_mismatch($sformatf("magenta_ink %0d, want %0d",
                                                  got.magenta_ink, want.magenta_ink));
                    if (got.yellow_ink !== want.yellow_ink)
                        report_mismatch($sformatf("yellow_ink %0d, want %0d",
                                                  got.yellow_ink, want.yellow_ink));
                    if (got.black_ink !== want.black_ink)
                        report_mismatch($sformatf("black_ink %0d, want %0d",
                                                  got.black_ink, want.black_ink));
                    if (got.bad_digit !== want.bad_digit)
                        report_mismatch($sformatf("bad_digit %0b, want %0b",
                                                  got.bad_digit, want.bad_digit));
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hex_bus.valid && hex_bus.ready) || (color_bus.valid && color_bus.ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_hex_rgb_to_cmyk: FAIL");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        hrc_pkg::in_word_t w;
        int                gap;
        clk             = 1'b0;
        rst_n           = 1'b0;
        hex_bus.valid   = 1'b0;
        hex_bus.data    = '0;
        color_bus.ready = 1'b0;

        // Directed words: extremes, both letter cases, grays and characters
        // just outside each hex range.
        queue_color(word_of("000000"), 0, 1'b0);
        queue_color(word_of("FFFFFF"), 0, 1'b0);
        queue_color(word_of("ffffff"), 1, 1'b0);
        queue_color(word_of("FF0000"), 0, 1'b0);
        queue_color(word_of("00ff00"), 2, 1'b0);
        queue_color(word_of("0000Ff"), 0, 1'b0);
        queue_color(word_of("808080"), 0, 1'b0);
        queue_color(word_of("0a1B2c"), 3, 1'b0);
        queue_color(word_of("9AbCdE"), 0, 1'b0);
        queue_color(word_of("fEdCbA"), 0, 1'b0);
        queue_color(word_of("7F7F00"), 0, 1'b0);
        queue_color(word_of("01FE80"), 5, 1'b0);
        queue_color(word_of("/:@G`g"), 0, 1'b0);
        queue_color(word_of("G00000"), 0, 1'b0);
        queue_color(word_of("0000g0"), 0, 1'b0);
        queue_color('0, 0, 1'b0);
        queue_color('1, 0, 1'b0);
        w = word_of("123456");
        w.red_high_digit = 8'hB1;   // '1' with bit 7 set is not a hex digit
        w.blue_low_digit = 8'hE6;   // 'f' with bit 7 set
        queue_color(w, 0, 1'b0);
        w = word_of("3a5C7e");
        w.green_low_digit = 8'h80;
        queue_color(w, 4, 1'b0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i >= BURST_FIRST && i <= BURST_LAST)
                gap = 0;
            else if (((i / 64) % 3) == 2)
                gap = 0;
            else
                gap = $urandom_range(0, MAX_IDLE);
            queue_color(random_color(), gap, (i == 0 || i == DRAIN_AT));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_colors.size() != 0 || hex_bus.valid)
            @(posedge clk);
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_colors.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                                      expected_colors.size()));

        if (errors == 0)
        begin
            $display("tb_hex_rgb_to_cmyk: PASS");
        end
        else
        begin
            $display("tb_hex_rgb_to_cmyk: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
sv/hrc_pkg.sv
sv/hrc_stream_if.sv
sv/hrc_chan_decode.sv
sv/hrc_key_merge.sv
sv/hrc_ink_div.sv
sv/hex_rgb_to_cmyk.sv
tb/tb_hex_rgb_to_cmyk.sv
